@@ rtl/rws_pkg.sv @@
`default_nettype none

package rws_pkg;

    localparam int MAX_POP  = 64;
    localparam int IDX_W    = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
    localparam int FILL_W   = $clog2(MAX_POP + 1);
    localparam int CFG_W    = 7;
    localparam int FIT_W    = 32;
    localparam int WORD_W   = 64;
    localparam int TOTAL_W  = 38;
    localparam int SUB_W    = TOTAL_W + 1;
    localparam int CNT_W    = $clog2(WORD_W);
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int PICK_W   = 6;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_FULL = 2'd2;

    localparam logic [CFG_W-1:0] POP_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_WALK = 3'b100
    } state_t;

    typedef struct packed {
        logic             borrow;
        logic [SUB_W-1:0] diff;
    } sub_res_t;

endpackage

`default_nettype wire

@@ rtl/rws_ram.sv @@
`default_nettype none

module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [$clog2(DEPTH)-1:0]          addr,
    input  wire logic [WIDTH-1:0]                  wdata,
    output logic      [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/rws_sub_unit.sv @@
`default_nettype none

module rws_sub_unit (
    input  wire logic [rws_pkg::SUB_W-1:0] a,
    input  wire logic [rws_pkg::SUB_W-1:0] b,
    output rws_pkg::sub_res_t              res
);

    logic [rws_pkg::SUB_W:0] wide;

    // borrow set means a < b
    assign wide = {1'b0, a} - {1'b0, b};
    assign res  = wide;

endmodule

`default_nettype wire

@@ rtl/roulette_wheel_selector_unit.sv @@
`default_nettype none

// channel  | handshake            | beat
// ---------+----------------------+------------------------------------------------
// command  | start & !busy        | command, fitness_value, random_word
// result   | done (one cycle)     | picked_index, total_fitness, best_index,
//          |                      | best_fitness, status
// config   | cfg_valid & cfg_ready| cfg_data (pop_size)
//
// clear, load, unused codes and a refused select stay in idle; done follows
// the accepting edge and busy stays low, so such commands can issue every cycle.
// a select runs one-bit restoring division of random_word on the shared subtractor,
// then walks the table one entry per cycle, up to pop_size entries; when the total
// is zero there is no walk.
// rst_n clears all control state at once; the table needs no clearing pass.
// the receiver cannot stall: each result is shown for exactly one cycle.

module roulette_wheel_selector_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rws_pkg::CMD_W-1:0]     command,
    input  wire logic [rws_pkg::FIT_W-1:0]     fitness_value,
    input  wire logic [rws_pkg::WORD_W-1:0]    random_word,
    output logic                               done,
    output logic [rws_pkg::PICK_W-1:0]         picked_index,
    output logic [rws_pkg::TOTAL_W-1:0]        total_fitness,
    output logic [rws_pkg::PICK_W-1:0]         best_index,
    output logic [rws_pkg::FIT_W-1:0]          best_fitness,
    output logic [rws_pkg::STAT_W-1:0]         status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rws_pkg::CFG_W-1:0]     cfg_data
);

    rws_pkg::state_t                  state_reg, state_next;
    logic [rws_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [rws_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic [rws_pkg::IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [rws_pkg::FIT_W-1:0]        best_val_reg, best_val_next;
    logic [rws_pkg::CFG_W-1:0]        pop_reg;
    logic [rws_pkg::WORD_W-1:0]       dvd_reg, dvd_next;
    logic [rws_pkg::TOTAL_W-1:0]      rem_reg, rem_next;
    logic [rws_pkg::TOTAL_W-1:0]      dsr_reg, dsr_next;
    logic [rws_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [rws_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [rws_pkg::PICK_W-1:0]       picked_reg, picked_next;
    logic [rws_pkg::STAT_W-1:0]       status_reg, status_next;
    logic                             done_reg, done_next;

    logic [rws_pkg::FILL_W-1:0]       n_eff;
    logic [rws_pkg::IDX_W-1:0]        n_last;
    logic                             accept;
    logic                             table_full;
    logic                             ram_we;
    logic [rws_pkg::IDX_W-1:0]        ram_addr;
    logic [rws_pkg::FIT_W-1:0]        ram_rdata;
    logic [rws_pkg::SUB_W-1:0]        sub_a, sub_b;
    rws_pkg::sub_res_t                sub_res;
    logic [rws_pkg::SUB_W-1:0]        div_shift;

    // effective population, clamped to 1..MAX_POP
    always_comb
    begin
        priority if (pop_reg == '0)
        begin
            n_eff = rws_pkg::FILL_W'(1);
        end
        else if (32'(pop_reg) > 32'(rws_pkg::MAX_POP))
        begin
            n_eff = rws_pkg::FILL_W'(rws_pkg::MAX_POP);
        end
        else
        begin
            n_eff = rws_pkg::FILL_W'(pop_reg);
        end
    end

    assign n_last     = rws_pkg::IDX_W'(n_eff - rws_pkg::FILL_W'(1));
    assign busy       = (state_reg != rws_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign table_full = (fill_reg >= n_eff);
    assign cfg_ready  = !busy && !start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg <= rws_pkg::POP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pop_reg <= cfg_data;
        end
    end

    assign ram_we = accept && (command == rws_pkg::CMD_LOAD) && !table_full;

    always_comb
    begin
        unique case (state_reg)
            rws_pkg::ST_IDLE: ram_addr = fill_reg[rws_pkg::IDX_W-1:0];
            rws_pkg::ST_DIV:  ram_addr = '0;
            rws_pkg::ST_WALK: ram_addr = idx_reg + rws_pkg::IDX_W'(1);
            default:          ram_addr = '0;
        endcase
    end

    rws_ram #(
        .WIDTH (rws_pkg::FIT_W),
        .DEPTH (rws_pkg::MAX_POP)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (fitness_value),
        .rdata (ram_rdata)
    );

    assign div_shift = {rem_reg, dvd_reg[rws_pkg::WORD_W-1]};

    always_comb
    begin
        if (state_reg == rws_pkg::ST_WALK)
        begin
            sub_a = rws_pkg::SUB_W'(rem_reg);
            sub_b = rws_pkg::SUB_W'(ram_rdata);
        end
        else
        begin
            sub_a = div_shift;
            sub_b = rws_pkg::SUB_W'(dsr_reg);
        end
    end

    rws_sub_unit u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        picked_next   = picked_reg;
        status_next   = status_reg;
        done_next     = 1'b0;

        unique case (state_reg)
            rws_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    picked_next = '0;
                    status_next = rws_pkg::STATUS_OK;
                    done_next   = 1'b1;
                    unique case (command)
                        rws_pkg::CMD_CLEAR:
                        begin
                            fill_next     = '0;
                            total_next    = '0;
                            best_idx_next = '0;
                            best_val_next = '0;
                        end
                        rws_pkg::CMD_LOAD:
                        begin
                            if (table_full)
                            begin
                                status_next = rws_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                total_next = total_reg
                                             + rws_pkg::TOTAL_W'(fitness_value);
                                if (fitness_value > best_val_reg)
                                begin
                                    best_val_next = fitness_value;
                                    best_idx_next = fill_reg[rws_pkg::IDX_W-1:0];
                                end
                                fill_next = fill_reg + rws_pkg::FILL_W'(1);
                            end
                        end
                        rws_pkg::CMD_SELECT:
                        begin
                            if (!table_full)
                            begin
                                status_next = rws_pkg::STATUS_NOT_FULL;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = rws_pkg::ST_DIV;
                                dvd_next   = random_word;
                                rem_next   = '0;
                                cnt_next   = '0;
                                idx_next   = '0;
                                if (total_reg == '0)
                                begin
                                    dsr_next = rws_pkg::TOTAL_W'(n_eff);
                                end
                                else
                                begin
                                    dsr_next = total_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rws_pkg::ST_DIV:
            begin
                // one restoring division step per cycle
                if (sub_res.borrow)
                begin
                    rem_next = div_shift[rws_pkg::TOTAL_W-1:0];
                end
                else
                begin
                    rem_next = sub_res.diff[rws_pkg::TOTAL_W-1:0];
                end
                dvd_next = {dvd_reg[rws_pkg::WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + rws_pkg::CNT_W'(1);
                if (cnt_reg == rws_pkg::CNT_W'(rws_pkg::WORD_W - 1))
                begin
                    if (total_reg == '0)
                    begin
                        picked_next = rws_pkg::PICK_W'(rem_next);
                        done_next   = 1'b1;
                        state_next  = rws_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = rws_pkg::ST_WALK;
                    end
                end
            end
            rws_pkg::ST_WALK:
            begin
                priority if (sub_res.borrow || (idx_reg == n_last))
                begin
                    picked_next = rws_pkg::PICK_W'(idx_reg);
                    done_next   = 1'b1;
                    state_next  = rws_pkg::ST_IDLE;
                end
                else
                begin
                    rem_next = sub_res.diff[rws_pkg::TOTAL_W-1:0];
                    idx_next = idx_reg + rws_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rws_pkg::ST_IDLE;
            fill_reg     <= '0;
            total_reg    <= '0;
            best_idx_reg <= '0;
            best_val_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            total_reg    <= total_next;
            best_idx_reg <= best_idx_next;
            best_val_reg <= best_val_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        picked_reg <= picked_next;
        status_reg <= status_next;
    end

    assign done          = done_reg;
    assign picked_index  = picked_reg;
    assign total_fitness = total_reg;
    assign best_index    = rws_pkg::PICK_W'(best_idx_reg);
    assign best_fitness  = best_val_reg;
    assign status        = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command != rws_pkg::CMD_SELECT)) |=> (done && !busy))
        else $error("one-cycle command gave no result");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == rws_pkg::STATUS_OK))
            |-> (rws_pkg::FILL_W'(picked_index) < n_eff))
        else $error("picked index outside population");

endmodule

`default_nettype wire

@@ bench/roulette_wheel_selector_unit_test.sv @@
module roulette_wheel_selector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rws_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int ITEM_TARGET   = 1900;
    localparam int SETTLE_CYCLES = 140;
    localparam int RESET_CYCLES  = 11;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [FIT_W-1:0]  fit;
        logic [WORD_W-1:0] word;
    } cmd_beat_t;

    typedef struct {
        logic [PICK_W-1:0]  picked;
        logic [TOTAL_W-1:0] total;
        logic [PICK_W-1:0]  best_idx;
        logic [FIT_W-1:0]   best_fit;
        logic [STAT_W-1:0]  stat;
    } outcome_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic [CMD_W-1:0]    command       = CMD_CLEAR;
    logic [FIT_W-1:0]    fitness_value = '0;
    logic [WORD_W-1:0]   random_word   = '0;
    logic                cfg_valid     = 1'b0;
    logic [CFG_W-1:0]    cfg_data      = POP_RESET;
    logic                busy;
    logic                done;
    logic [PICK_W-1:0]   picked_index;
    logic [TOTAL_W-1:0]  total_fitness;
    logic [PICK_W-1:0]   best_index;
    logic [FIT_W-1:0]    best_fitness;
    logic [STAT_W-1:0]   status;
    logic                cfg_ready;

    roulette_wheel_selector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .fitness_value (fitness_value),
        .random_word   (random_word),
        .done          (done),
        .picked_index  (picked_index),
        .total_fitness (total_fitness),
        .best_index    (best_index),
        .best_fitness  (best_fitness),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // command beats waiting for the driver, results still owed by the block
    cmd_beat_t cmds_waiting[$];
    outcome_t  outcomes_due[$];

    logic [FIT_W-1:0]   wheel_tab [MAX_POP];
    logic [FILL_W-1:0]  loaded_cnt = '0;
    logic [TOTAL_W-1:0] fit_sum    = '0;
    logic [IDX_W-1:0]   lead_idx   = '0;
    logic [FIT_W-1:0]   lead_val   = '0;
    logic [CFG_W-1:0]   pop_reg    = POP_RESET;

    int  failures   = 0;
    int  issued     = 0;
    int  gap_left   = 0;
    int  quiet      = 0;
    bit  no_idle    = 1'b0;

    function automatic int live_size();
        int n;
        n = pop_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_POP)
            n = MAX_POP;
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] wheel_pick(logic [WORD_W-1:0] word, int n);
        logic [WORD_W-1:0] rem;
        int hit;
        if (fit_sum == '0)
            return IDX_W'(word % WORD_W'(n));
        rem = word % {{(WORD_W-TOTAL_W){1'b0}}, fit_sum};
        hit = n - 1;
        for (int i = 0; i < n; i++)
        begin
            if (rem < WORD_W'(wheel_tab[i]))
            begin
                hit = i;
                break;
            end
            rem = rem - WORD_W'(wheel_tab[i]);
        end
        return IDX_W'(hit);
    endfunction

    task automatic apply_command(logic [CMD_W-1:0] cmd, logic [FIT_W-1:0] fit,
                                 logic [WORD_W-1:0] word);
        outcome_t o;
        int n;
        n = live_size();
        o.picked = '0;
        o.stat = STATUS_OK;
        case (cmd)
            CMD_CLEAR:
            begin
                loaded_cnt = '0;
                fit_sum = '0;
                lead_idx = '0;
                lead_val = '0;
            end
            CMD_LOAD:
            begin
                if (loaded_cnt >= n)
                    o.stat = STATUS_FULL;
                else
                begin
                    wheel_tab[loaded_cnt[IDX_W-1:0]] = fit;
                    fit_sum = fit_sum + TOTAL_W'(fit);
                    if (fit > lead_val)
                    begin
                        lead_val = fit;
                        lead_idx = loaded_cnt[IDX_W-1:0];
                    end
                    loaded_cnt = loaded_cnt + 1'b1;
                end
            end
            CMD_SELECT:
            begin
                if (loaded_cnt < n)
                    o.stat = STATUS_NOT_FULL;
                else
                    o.picked = wheel_pick(word, n);
            end
            default:
            begin
            end
        endcase
        o.total = fit_sum;
        o.best_idx = lead_idx;
        o.best_fit = lead_val;
        outcomes_due.push_back(o);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        cmd_beat_t b;
        bit keep;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            keep = 1'b0;
            if (start && !busy)
            begin
                apply_command(command, fitness_value, random_word);
                gap_left = no_idle ? 0 : $urandom_range(0, 3);
            end
            else if (start)
                keep = 1'b1;
            if (!keep)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmds_waiting.size() > 0)
                begin
                    b = cmds_waiting.pop_front();
                    command <= b.cmd;
                    fitness_value <= b.fit;
                    random_word <= b.word;
                    keep = 1'b1;
                end
            end
            start <= keep;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected result picked_index %0h status %0h",
                         $time, picked_index, status);
                failures++;
            end
            else
            begin
                w = outcomes_due.pop_front();
                check_field("picked_index", 64'(w.picked), 64'(picked_index));
                check_field("total_fitness", 64'(w.total), 64'(total_fitness));
                check_field("best_index", 64'(w.best_idx), 64'(best_index));
                check_field("best_fitness", 64'(w.best_fit), 64'(best_fitness));
                check_field("status", 64'(w.stat), 64'(status));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet + 1 >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic [FIT_W-1:0] draw_fit(int style);
        case (style)
            0: return '0;
            1: return FIT_W'($urandom_range(0, 15));
            2: return $urandom();
            3: return ($urandom_range(0, 7) == 0) ? FIT_W'($urandom()) : '0;
            default: return ($urandom_range(0, 1) == 1) ? '1 : FIT_W'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(0, 255));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] draw_pop();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: return CFG_W'($urandom_range(1, 4));
            6, 7, 8, 9, 10, 11, 12, 13: return CFG_W'($urandom_range(5, 16));
            14, 15, 16: return CFG_W'($urandom_range(17, 63));
            default: return CFG_W'(MAX_POP);
        endcase
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [FIT_W-1:0] fit,
                             logic [WORD_W-1:0] word);
        cmd_beat_t b;
        b.cmd = cmd;
        b.fit = fit;
        b.word = word;
        cmds_waiting.push_back(b);
        if (cmd != CMD_UNUSED)
            issued++;
    endtask

    task automatic queue_noise();
        queue_cmd(CMD_W'($urandom_range(0, 3)), draw_fit($urandom_range(0, 4)), draw_word());
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (cmds_waiting.size() != 0 || start || outcomes_due.size() != 0);
    endtask

    task automatic write_pop(logic [CFG_W-1:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        pop_reg = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int n;
        int style;
        int kind;
        int phase;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on a population of four
        write_pop(CFG_W'(4));
        queue_cmd(CMD_SELECT, '0, '1);
        queue_cmd(CMD_UNUSED, '1, '1);
        repeat (4) queue_cmd(CMD_LOAD, '0, '0);
        queue_cmd(CMD_SELECT, '0, '1);
        queue_cmd(CMD_SELECT, '1, '0);
        queue_cmd(CMD_LOAD, '1, '0);
        queue_cmd(CMD_CLEAR, '1, '1);
        queue_cmd(CMD_LOAD, '1, '0);
        queue_cmd(CMD_LOAD, '0, '0);
        queue_cmd(CMD_LOAD, '1, '0);
        queue_cmd(CMD_LOAD, FIT_W'(1), '0);
        queue_cmd(CMD_SELECT, '0, '1);
        queue_cmd(CMD_SELECT, '0, '0);
        queue_cmd(CMD_SELECT, '0, 64'h1_FFFF_FFFE);
        queue_cmd(CMD_CLEAR, '0, '0);
        queue_cmd(CMD_UNUSED, $urandom(), {$urandom(), $urandom()});

        phase = 0;
        while (issued < ITEM_TARGET)
        begin
            if (phase == 0)
                write_pop(CFG_W'(1));
            else if (phase == 1)
                write_pop(CFG_W'(MAX_POP));
            else if ($urandom_range(0, 1) == 1)
                write_pop(draw_pop());
            else if ($urandom_range(0, 3) == 0)
                drain();
            no_idle = ($urandom_range(0, 3) == 0);
            n = live_size();
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                // one generation: usually clear, fill the table, spin a few times
                if (kind != 0)
                    queue_cmd(CMD_CLEAR, $urandom(), draw_word());
                style = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        queue_noise();
                    queue_cmd(CMD_LOAD, draw_fit(style), draw_word());
                end
                repeat ($urandom_range(1, 6)) queue_cmd(CMD_SELECT, $urandom(), draw_word());
            end
            else
                repeat ($urandom_range(4, 20)) queue_noise();
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outcomes_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
